// ===== design/bcsa_pkg.sv =====
`timescale 1ns / 1ps
package bcsa_pkg;

  localparam int MAP_WORDS = 1024;
  localparam int WORD_BITS = 64;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WIU_W     = 11;
  localparam int WRAP_W    = 4;
  localparam int CNT_W     = 17;
  localparam int SEG_W     = 16;
  localparam int CFG_W     = 11;

  localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

  localparam logic CFG_WORDS_IN_USE = 1'b0;
  localparam logic CFG_MAX_WRAPS    = 1'b1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SIZE = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_CHK,
    S_SCAN_EVAL,
    S_MARK_RD,
    S_MARK_WR,
    S_FREE_WR,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic             mode;
    logic [CNT_W-1:0] seg_count;
    logic [SEG_W-1:0] seg_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SEG_W-1:0] base_segment;
  } out_item_t;

endpackage

// ===== design/bcsa_ram.sv =====
`timescale 1ns / 1ps
module bcsa_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/bitmap_contiguous_segment_allocator.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake                   Payload
// in       input      in_valid_i / in_ready_o     in_item_i  (mode, seg_count, seg_index)
// out      output     out_valid_o / out_ready_i   out_item_o (status, base_segment)
// cfg      input      cfg_we_i                    cfg_index_i, cfg_data_i
//
// One item at a time. A free item in range passes through read, write and result load;
// a zero-size item or a free beyond the map passes through accept and result load.
// An allocate item takes a map RAM read and an evaluate step per scanned word,
// a wrap step per wrap to word 0, a read-modify-write per word of the granted run,
// plus accept and result load.
// Scan time is set by the single map RAM read port and its registered read.
// After reset a clearing pass writes all 1024 map words free; no item is
// accepted until it ends. A finished result waits in the output register;
// the next item is accepted while it is not yet taken.
module bitmap_contiguous_segment_allocator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  bcsa_pkg::in_item_t       in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output bcsa_pkg::out_item_t      out_item_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [bcsa_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int AW = bcsa_pkg::ADDR_W;
  localparam int WB = bcsa_pkg::WORD_BITS;
  localparam int BW = bcsa_pkg::BIT_W;

  bcsa_pkg::fsm_e state_q, state_d;

  // configuration
  logic [bcsa_pkg::WIU_W-1:0]  words_q;
  logic [bcsa_pkg::WRAP_W-1:0] wraps_max_q;
  logic [bcsa_pkg::WIU_W-1:0]  n_words;

  // search state
  logic [AW-1:0]              cursor_q, cursor_d;
  logic [AW:0]                w_q, w_d;
  logic [bcsa_pkg::WRAP_W-1:0] wraps_q, wraps_d;
  logic [bcsa_pkg::CNT_W-1:0] len_q, len_d;
  logic [bcsa_pkg::CNT_W-1:0] pend_q, pend_d;
  logic [bcsa_pkg::SEG_W-1:0] base_q, base_d;
  logic [bcsa_pkg::SEG_W-1:0] idx_q, idx_d;
  logic [AW-1:0]              mw_q, mw_d;
  logic [AW-1:0]              clr_q, clr_d;

  bcsa_pkg::out_item_t res_q, res_d;
  bcsa_pkg::out_item_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WB-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WB-1:0] ram_rdata;

  // word evaluation
  logic [bcsa_pkg::CNT_W-1:0] need;
  logic [BW:0]                take, take_all, top;
  logic [WB-1:0]              low_m;
  logic [WB-1:0]              pw [BW+1];
  logic [2:0]                 msb;
  logic [BW:0]                span;
  logic [WB-1:0]              run_m;
  logic                       run_hit;
  logic [BW-1:0]              run_s;
  logic [bcsa_pkg::CNT_W-1:0] pend_sum;
  logic [bcsa_pkg::SEG_W-1:0] wbase;

  // run marking
  logic [bcsa_pkg::SEG_W-1:0] end_seg;
  logic [BW-1:0]              lo_b, hi_b;
  logic [WB-1:0]              mark_m;
  logic                       in_acc;

  assign n_words = (words_q > bcsa_pkg::WIU_W'(bcsa_pkg::MAP_WORDS))
                   ? bcsa_pkg::WIU_W'(bcsa_pkg::MAP_WORDS) : words_q;

  bcsa_ram #(.Width(WB), .Depth(bcsa_pkg::MAP_WORDS)) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Word evaluation on the RAM read data
  // ---------------------------------------------------------------------
  always_comb begin
    need     = len_q - pend_q;
    take     = (need > bcsa_pkg::CNT_W'(WB)) ? (BW+1)'(WB) : need[BW:0];
    take_all = (len_q > bcsa_pkg::CNT_W'(WB)) ? (BW+1)'(WB) : len_q[BW:0];
    low_m    = bcsa_pkg::ALL_ONES >> ((BW+1)'(WB) - take);
    pend_sum = pend_q + bcsa_pkg::CNT_W'(take);
    wbase    = {w_q[AW-1:0], BW'(0)};

    // pw[k]: starts of runs of 2^k ones
    pw[0] = ram_rdata;
    for (int k = 1; k <= BW; k++) begin
      pw[k] = pw[k-1] & (pw[k-1] >> (1 << (k-1)));
    end
    // run of L ones = two overlapping runs of 2^msb(L)
    msb = '0;
    for (int k = 0; k <= BW; k++) begin
      if (take_all[k]) msb = 3'(k);
    end
    span  = take_all - ((BW+1)'(1) << msb);
    run_m = pw[msb] & (pw[msb] >> span);

    run_hit = 1'b0;
    run_s   = '0;
    for (int i = WB-1; i >= 0; i--) begin
      if (run_m[i]) begin
        run_hit = 1'b1;
        run_s   = BW'(i);
      end
    end

    // ones ending at the top bit
    top = (BW+1)'(WB);
    for (int i = 0; i < WB; i++) begin
      if (!ram_rdata[i]) top = (BW+1)'(WB - 1 - i);
    end
  end

  // marking mask over one word of the granted run
  always_comb begin
    end_seg = base_q + len_q[bcsa_pkg::SEG_W-1:0] - bcsa_pkg::SEG_W'(1);
    lo_b    = (mw_q == base_q[bcsa_pkg::SEG_W-1 -: AW]) ? base_q[BW-1:0] : '0;
    hi_b    = (mw_q == end_seg[bcsa_pkg::SEG_W-1 -: AW]) ? end_seg[BW-1:0] : '1;
    mark_m  = (bcsa_pkg::ALL_ONES << lo_b) & (bcsa_pkg::ALL_ONES >> (BW'(WB - 1) - hi_b));
  end

  assign in_ready_o = (state_q == bcsa_pkg::S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    w_d         = w_q;
    wraps_d     = wraps_q;
    len_d       = len_q;
    pend_d      = pend_q;
    base_d      = base_q;
    idx_d       = idx_q;
    mw_d        = mw_q;
    clr_d       = clr_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = mw_q;
    ram_wdata   = ram_rdata & ~mark_m;
    ram_raddr   = w_q[AW-1:0];

    unique case (state_q)
      bcsa_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = bcsa_pkg::ALL_ONES;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(bcsa_pkg::MAP_WORDS - 1)) state_d = bcsa_pkg::S_IDLE;
      end

      bcsa_pkg::S_IDLE: begin
        ram_raddr = in_item_i.seg_index[bcsa_pkg::SEG_W-1 -: AW];
        if (in_acc) begin
          idx_d = in_item_i.seg_index;
          if (in_item_i.mode == bcsa_pkg::MODE_FREE) begin
            if (bcsa_pkg::WIU_W'(in_item_i.seg_index[bcsa_pkg::SEG_W-1 -: AW]) < n_words) begin
              state_d = bcsa_pkg::S_FREE_WR;
            end else begin
              res_d   = '{status: bcsa_pkg::ST_BAD_INDEX, base_segment: '0};
              state_d = bcsa_pkg::S_DONE;
            end
          end else if (in_item_i.seg_count == '0) begin
            res_d   = '{status: bcsa_pkg::ST_ZERO_SIZE, base_segment: '0};
            state_d = bcsa_pkg::S_DONE;
          end else begin
            len_d   = in_item_i.seg_count;
            w_d     = {1'b0, cursor_q};
            wraps_d = '0;
            pend_d  = '0;
            state_d = bcsa_pkg::S_SCAN_CHK;
          end
        end
      end

      bcsa_pkg::S_SCAN_CHK: begin
        // read of word w_q issued here when it is in range
        if (bcsa_pkg::WIU_W'(w_q) >= n_words) begin
          pend_d = '0;
          if (wraps_q == wraps_max_q) begin
            cursor_d = '0;
            res_d    = '{status: bcsa_pkg::ST_NO_SPACE, base_segment: '0};
            state_d  = bcsa_pkg::S_DONE;
          end else begin
            wraps_d = wraps_q + bcsa_pkg::WRAP_W'(1);
            w_d     = '0;
          end
        end else begin
          state_d = bcsa_pkg::S_SCAN_EVAL;
        end
      end

      bcsa_pkg::S_SCAN_EVAL: begin
        state_d = bcsa_pkg::S_SCAN_CHK;
        w_d     = w_q + (AW+1)'(1);
        if (ram_rdata == '0) begin
          pend_d = '0;
        end else if ((ram_rdata & low_m) == low_m) begin
          // continue pending run, or start one at bit 0
          if (pend_q == '0) base_d = wbase;
          pend_d = pend_sum;
          if (pend_sum == len_q) begin
            w_d     = w_q;
            mw_d    = (pend_q == '0) ? w_q[AW-1:0] : base_q[bcsa_pkg::SEG_W-1 -: AW];
            state_d = bcsa_pkg::S_MARK_RD;
          end
        end else begin
          pend_d = '0;
          if (run_hit && (bcsa_pkg::CNT_W'(take_all) == len_q)) begin
            base_d  = wbase + bcsa_pkg::SEG_W'(run_s);
            w_d     = w_q;
            mw_d    = w_q[AW-1:0];
            state_d = bcsa_pkg::S_MARK_RD;
          end else if (top != '0) begin
            base_d = wbase + bcsa_pkg::SEG_W'((BW+1)'(WB) - top);
            pend_d = bcsa_pkg::CNT_W'(top);
          end
        end
      end

      bcsa_pkg::S_MARK_RD: begin
        ram_raddr = mw_q;
        state_d   = bcsa_pkg::S_MARK_WR;
      end

      bcsa_pkg::S_MARK_WR: begin
        ram_we    = 1'b1;
        ram_waddr = mw_q;
        ram_wdata = ram_rdata & ~mark_m;
        if (mw_q == end_seg[bcsa_pkg::SEG_W-1 -: AW]) begin
          cursor_d = mw_q;
          res_d    = '{status: bcsa_pkg::ST_OK, base_segment: base_q};
          state_d  = bcsa_pkg::S_DONE;
        end else begin
          mw_d    = mw_q + AW'(1);
          state_d = bcsa_pkg::S_MARK_RD;
        end
      end

      bcsa_pkg::S_FREE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[bcsa_pkg::SEG_W-1 -: AW];
        ram_wdata = ram_rdata | (WB'(1) << idx_q[BW-1:0]);
        res_d     = '{status: bcsa_pkg::ST_OK, base_segment: '0};
        state_d   = bcsa_pkg::S_DONE;
      end

      bcsa_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = bcsa_pkg::S_IDLE;
        end
      end

      default: state_d = bcsa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcsa_pkg::S_CLEAR;
      clr_q       <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
      words_q     <= bcsa_pkg::WIU_W'(1024);
      wraps_max_q <= bcsa_pkg::WRAP_W'(1);
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cursor_q    <= cursor_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          bcsa_pkg::CFG_WORDS_IN_USE: words_q     <= cfg_data_i[bcsa_pkg::WIU_W-1:0];
          bcsa_pkg::CFG_MAX_WRAPS:    wraps_max_q <= cfg_data_i[bcsa_pkg::WRAP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    wraps_q <= wraps_d;
    len_q   <= len_d;
    pend_q  <= pend_d;
    base_q  <= base_d;
    idx_q   <= idx_d;
    mw_q    <= mw_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
